FILE: hdl/sha256_counter_keystream_xor_defines.svh
// assertion macros for the keystream block
`ifndef SHA256_COUNTER_KEYSTREAM_XOR_DEFINES_SVH
`define SHA256_COUNTER_KEYSTREAM_XOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SKX_ASSERT_IMPL(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");
`define SKX_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");
`else
`define SKX_ASSERT_IMPL(label, clk, rst, cond, conseq)
`define SKX_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

FILE: hdl/skx_pkg.sv
`timescale 1ns / 1ps
package skx_pkg;
   localparam int MaxDigits = 8;
   localparam int CntW = 4 * MaxDigits;
   localparam int DcW = $clog2(MaxDigits + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       counter_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_KEY_WORD_0  = 3'd0,
      CSR_KEY_WORD_1  = 3'd1,
      CSR_KEY_WORD_2  = 3'd2,
      CSR_KEY_WORD_3  = 3'd3,
      CSR_NONCE_HIGH  = 3'd4,
      CSR_NONCE_LOW   = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // latch request, apply message start
      logic blk_init;    // load message block, hash words from iv if first
      logic round;       // one compression round
      logic add;         // fold working vars into hash words
      logic emit;        // form result, advance position
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_hash;   // block position is zero
      logic last_round;
      logic more_blocks; // another padded block follows
   } status_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
endpackage

FILE: hdl/sha256_counter_keystream_xor.sv
`timescale 1ns / 1ps
// channel | ports                          | word
// req     | req_valid req_ready req_data   | data_byte, message_start
// rsp     | rsp_valid rsp_ready rsp_data   | out_byte, counter_overflow
// csr     | csr_valid csr_ready csr_index csr_wdata | register write
// a byte inside a block passes the idle, load and out states, the last one offering the response
// a block's first byte also passes round and add states per compression (one or two, by digit count)
// the shared round unit does one sha-256 round per cycle
// synchronous reset clears counter, position, overflow and registers
// one word at a time; a stalled response holds the next request off
module sha256_counter_keystream_xor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  skx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output skx_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import skx_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   skx_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .status);

   skx_datapath u_dp (
      .clock, .reset, .req_data, .rsp_data,
      .csr_we(csr_valid), .csr_index, .csr_wdata, .cmd, .status);
endmodule

FILE: hdl/skx_ctrl.sv
`timescale 1ns / 1ps
`include "sha256_counter_keystream_xor_defines.svh"
module skx_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output skx_pkg::cmd_type   cmd,
   input  skx_pkg::status_type status
);
   import skx_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // result held in ST_OUT; input taken only from idle
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.need_hash) begin
               cmd.blk_init = 1'b1;
               state_in     = ST_ROUND;
            end else begin
               cmd.emit = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.last_round) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            if (status.more_blocks) state_in = ST_LOAD;
            else begin
               cmd.emit = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SKX_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !rsp_valid)
   `SKX_ASSERT_NEXT(a_take_load, clock, reset, req_valid && req_ready, state_ff == ST_LOAD)
   `SKX_ASSERT_NEXT(a_round_holds, clock, reset,
      state_ff == ST_ROUND && !status.last_round, state_ff == ST_ROUND)
endmodule

FILE: hdl/skx_datapath.sv
`timescale 1ns / 1ps
`include "sha256_counter_keystream_xor_defines.svh"
module skx_datapath (
   input  logic                clock,
   input  logic                reset,
   input  skx_pkg::req_type    req_data,
   output skx_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   input  skx_pkg::cmd_type    cmd,
   output skx_pkg::status_type status
);
   import skx_pkg::*;

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nhi_ff, nlo_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [DcW-1:0]  dc_ff, dc_in;
   logic [4:0]      pos_ff;
   logic            ovf_ff, ovf_in;
   logic            blk_ff;    // which padded block
   logic            first_ff;  // unused; blk_ff at zero marks the first block
   logic [5:0]      rnd_ff;
   logic [7:0]      data_ff;
   logic [31:0]     h_ff [8];
   logic [31:0]     v_ff [8];
   logic [31:0]     w_ff [16];
   logic [7:0]      obyte_ff;
   logic            oovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; key3_ff <= '0;
         nhi_ff <= '0; nlo_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_WORD_0: key0_ff <= csr_wdata;
            CSR_KEY_WORD_1: key1_ff <= csr_wdata;
            CSR_KEY_WORD_2: key2_ff <= csr_wdata;
            CSR_KEY_WORD_3: key3_ff <= csr_wdata;
            CSR_NONCE_HIGH: nhi_ff  <= csr_wdata;
            CSR_NONCE_LOW:  nlo_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // message tail: ascii digits, 0x80, zeros, length; up to 8+1 bytes after 48
   logic [10:0] len_bits;
   logic [7:0]  tail [80];   // bytes 48..127
   logic        two_blocks;
   always_comb begin
      for (int i = 0; i < 80; i++) tail[i] = 8'h00;
      for (int i = 0; i < MaxDigits; i++) begin
         if (i < int'(dc_ff))
            tail[i] = 8'h30 | {4'h0, cnt_ff[4*(int'(dc_ff)-1-i) +: 4]};
         else if (i == int'(dc_ff))
            tail[i] = 8'h80;
      end
      if (dc_ff == DcW'(MaxDigits)) tail[MaxDigits] = 8'h80;
      len_bits   = 11'(48 + int'(dc_ff)) << 3;
      two_blocks = (48 + int'(dc_ff) + 9) > 64;
      if (two_blocks) begin
         tail[78] = {5'b00000, len_bits[10:8]};
         tail[79] = len_bits[7:0];
      end else begin
         tail[14] = {5'b00000, len_bits[10:8]};
         tail[15] = len_bits[7:0];
      end
   end

   logic [31:0] blk_w [16];
   always_comb begin
      if (!blk_ff) begin
         blk_w[0] = key0_ff[63:32]; blk_w[1] = key0_ff[31:0];
         blk_w[2] = key1_ff[63:32]; blk_w[3] = key1_ff[31:0];
         blk_w[4] = key2_ff[63:32]; blk_w[5] = key2_ff[31:0];
         blk_w[6] = key3_ff[63:32]; blk_w[7] = key3_ff[31:0];
         blk_w[8] = nhi_ff[63:32];  blk_w[9] = nhi_ff[31:0];
         blk_w[10] = nlo_ff[63:32]; blk_w[11] = nlo_ff[31:0];
         for (int i = 0; i < 4; i++)
            blk_w[12+i] = {tail[4*i], tail[4*i+1], tail[4*i+2], tail[4*i+3]};
      end else begin
         for (int i = 0; i < 16; i++)
            blk_w[i] = {tail[16+4*i], tail[17+4*i], tail[18+4*i], tail[19+4*i]};
      end
   end

   // one round; schedule kept as 16-word shift line
   logic [31:0] wt, s0, s1, t1, t2, ch, maj, e1, a0;
   always_comb begin
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
         ^ (w_ff[14] >> 10);
      wt = w_ff[0];
      e1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
         ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      a0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
         ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1 = v_ff[7] + e1 + ch + RoundK[rnd_ff] + wt;
      t2 = a0 + maj;
   end

   // bcd increment, one digit lane per position
   always_comb begin
      logic carry;
      carry  = 1'b1;
      cnt_in = cnt_ff;
      dc_in  = dc_ff;
      ovf_in = ovf_ff;
      for (int i = 0; i < MaxDigits; i++) begin
         if (carry && i < int'(dc_ff)) begin
            if (cnt_ff[4*i +: 4] < 4'd9) begin
               cnt_in[4*i +: 4] = cnt_ff[4*i +: 4] + 4'd1;
               carry = 1'b0;
            end else cnt_in[4*i +: 4] = 4'd0;
         end
      end
      if (carry) begin
         if (dc_ff < DcW'(MaxDigits)) begin
            cnt_in[4*int'(dc_ff[DcW-1:0]) +: 4] = 4'd1;
            dc_in = dc_ff + DcW'(1);
         end else begin
            for (int i = 0; i < MaxDigits; i++) cnt_in[4*i +: 4] = 4'd9;
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; dc_ff <= DcW'(1); pos_ff <= '0; ovf_ff <= 1'b0;
         blk_ff <= 1'b0; rnd_ff <= '0;
      end else begin
         if (cmd.take && req_data.message_start) begin
            cnt_ff <= '0; dc_ff <= DcW'(1); pos_ff <= '0; ovf_ff <= 1'b0;
         end
         if (cmd.blk_init) rnd_ff <= '0;
         if (cmd.round) rnd_ff <= rnd_ff + 6'd1;
         // the add that ends a digest leaves this at zero
         if (cmd.add) blk_ff <= two_blocks && !blk_ff;
         if (cmd.emit) begin
            pos_ff <= pos_ff + 5'd1;
            if (pos_ff == 5'd31) begin
               cnt_ff <= cnt_in; dc_ff <= dc_in; ovf_ff <= ovf_in;
            end
         end
      end
   end

   // digest byte; when emitting in the add cycle, that cycle's sum is used
   function automatic logic [7:0] ksel(input logic [4:0] p);
      logic [31:0] hw;
      hw = cmd.add ? h_ff[p[4:2]] + v_ff[p[4:2]] : h_ff[p[4:2]];
      return hw[8*(3-int'(p[1:0])) +: 8];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.take) data_ff <= req_data.data_byte;
      if (cmd.blk_init) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= blk_w[i];
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= blk_ff ? h_ff[i] : InitH[i];
            if (!blk_ff) h_ff[i] <= InitH[i];
         end
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_ff[0] + s0 + w_ff[9] + s1;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (cmd.add)
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      if (cmd.emit) begin
         obyte_ff <= data_ff ^ ksel(pos_ff);
         oovf_ff  <= ovf_ff;
      end
   end

   assign status.need_hash   = (pos_ff == 5'd0);
   assign status.last_round  = (rnd_ff == 6'd63);
   assign status.more_blocks = two_blocks && !blk_ff;
   assign rsp_data.out_byte         = obyte_ff;
   assign rsp_data.counter_overflow = oovf_ff;

   `SKX_ASSERT_IMPL(a_dc_range, clock, reset, 1'b1,
      dc_ff >= DcW'(1) && dc_ff <= DcW'(MaxDigits))
   `SKX_ASSERT_NEXT(a_ovf_sticky, clock, reset,
      ovf_ff && !(cmd.take && req_data.message_start), ovf_ff)
   `SKX_ASSERT_NEXT(a_round_step, clock, reset, cmd.round && !status.last_round,
      rnd_ff == $past(rnd_ff) + 6'd1)
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import skx_pkg::*;

   localparam int CycleLimit = 400000;
   localparam logic [2:0] CsrSpare6 = 3'd6;
   localparam logic [2:0] CsrSpare7 = 3'd7;

   class keystream_scoreboard;
      logic [63:0] key_nonce [6];
      logic [31:0] bcd_count;
      int          num_digits;
      int          byte_pos;
      bit          saturated;
      logic [7:0]  ks [32];
      rsp_type     expected_bytes [$];
      int          errors;

      function new();
         for (int i = 0; i < 6; i++) key_nonce[i] = '0;
         bcd_count = '0;
         num_digits = 1;
         byte_pos = 0;
         saturated = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            CSR_KEY_WORD_0: key_nonce[0] = val;
            CSR_KEY_WORD_1: key_nonce[1] = val;
            CSR_KEY_WORD_2: key_nonce[2] = val;
            CSR_KEY_WORD_3: key_nonce[3] = val;
            CSR_NONCE_HIGH: key_nonce[4] = val;
            CSR_NONCE_LOW:  key_nonce[5] = val;
            default: ;
         endcase
      endfunction

      function automatic logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // sha-256 of key, nonce and the ascii counter
      function void hash_block();
         logic [7:0]  m [128];
         logic [31:0] w [64];
         logic [31:0] h [8];
         logic [31:0] v [8];
         logic [31:0] t1, t2, s0, s1;
         logic [63:0] bits;
         int len, nb;
         for (int i = 0; i < 128; i++) m[i] = 8'h00;
         for (int i = 0; i < 6; i++)
            for (int j = 0; j < 8; j++) m[8*i+j] = key_nonce[i][63-8*j -: 8];
         len = 48;
         for (int i = 0; i < num_digits; i++) begin
            m[len] = 8'h30 + 8'(bcd_count[4*(num_digits-1-i) +: 4]);
            len++;
         end
         m[len] = 8'h80;
         nb = (len + 72) / 64;
         bits = 64'(len) * 8;
         for (int j = 0; j < 8; j++) m[64*nb-8+j] = bits[63-8*j -: 8];
         for (int i = 0; i < 8; i++) h[i] = InitH[i];
         for (int b = 0; b < nb; b++) begin
            for (int i = 0; i < 16; i++)
               w[i] = {m[64*b+4*i], m[64*b+4*i+1], m[64*b+4*i+2], m[64*b+4*i+3]};
            for (int i = 16; i < 64; i++) begin
               s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
               s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
               w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = h[i];
            for (int t = 0; t < 64; t++) begin
               t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                  + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
               t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                  + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
               v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
               v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
         end
         for (int i = 0; i < 8; i++)
            for (int j = 0; j < 4; j++) ks[4*i+j] = h[i][31-8*j -: 8];
      endfunction

      function void bump_counter();
         for (int i = 0; i < num_digits; i++) begin
            if (bcd_count[4*i +: 4] < 4'd9) begin
               bcd_count[4*i +: 4] = bcd_count[4*i +: 4] + 4'd1;
               return;
            end
            bcd_count[4*i +: 4] = 4'd0;
         end
         if (num_digits < MaxDigits) begin
            bcd_count[4*num_digits +: 4] = 4'd1;
            num_digits++;
            return;
         end
         // all nines at full width: hold there
         for (int i = 0; i < MaxDigits; i++) bcd_count[4*i +: 4] = 4'd9;
         saturated = 1;
      endfunction

      function void note_input(req_type r);
         rsp_type e;
         if (r.message_start) begin
            bcd_count = '0;
            num_digits = 1;
            byte_pos = 0;
            saturated = 0;
         end
         if (byte_pos == 0) hash_block();
         e.out_byte = r.data_byte ^ ks[byte_pos];
         e.counter_overflow = saturated;
         expected_bytes.push_back(e);
         byte_pos = (byte_pos + 1) % 32;
         if (byte_pos == 0) bump_counter();
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word: %h", got);
            return;
         end
         e = expected_bytes.pop_front();
         if (got.out_byte !== e.out_byte || got.counter_overflow !== e.counter_overflow) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected byte %h ovf %b, got byte %h ovf %b",
                        e.out_byte, e.counter_overflow, got.out_byte, got.counter_overflow);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   keystream_scoreboard sb;
   bit allow_idle;
   int stall_left;
   int cycle_count;

   sha256_counter_keystream_xor u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: check accepted words, stall in short bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (allow_idle && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
         end
      end
   end

   task automatic send_byte(logic [7:0] d, logic start);
      req_type r;
      r.data_byte = d;
      r.message_start = start;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_input(r);
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3, logic [63:0] nh, logic [63:0] nl);
      write_reg(CSR_KEY_WORD_0, k0);
      write_reg(CSR_KEY_WORD_1, k1);
      write_reg(CSR_KEY_WORD_2, k2);
      write_reg(CSR_KEY_WORD_3, k3);
      write_reg(CSR_NONCE_HIGH, nh);
      write_reg(CSR_NONCE_LOW, nl);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_messages(int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 40);
         // a message start now and then omitted, so messages run on
         for (int i = 0; i < len && sent < count; i++) begin
            send_byte(8'($urandom), (i == 0) ? ($urandom_range(0, 7) != 0) : 1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_WORD_0;
      csr_wdata = '0;
      allow_idle = 1'b1;
      stall_left = 0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero key and nonce, field extremes and a restart mid-block
      write_all('0, '0, '0, '0, '0, '0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      for (int i = 0; i < 18; i++) send_byte(8'($urandom), 1'b0);
      drain();

      // all-ones registers; spare indexes are ignored
      write_all('1, '1, '1, '1, '1, '1);
      write_reg(CsrSpare6, rand64());
      write_reg(CsrSpare7, rand64());
      csr_valid <= 1'b0;
      random_messages(200);
      drain();

      write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      // long message: the counter grows past one digit
      send_byte(8'($urandom), 1'b1);
      for (int i = 0; i < 349; i++) send_byte(8'($urandom), 1'b0);
      drain();

      write_all(rand64(), '0, '1, rand64(), rand64(), '0);
      random_messages(250);
      drain();

      write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      allow_idle = 1'b0;
      random_messages(100);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
